>>> rtl/cwr_pkg.sv
package cwr_pkg;

  localparam int LOC_OUT_W = 11;
  localparam int CELL_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int COLOUR_W  = 4;

  localparam logic [7:0]        CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0]        CHAR_TAB       = 8'h09;
  localparam logic [7:0]        CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0]        CHAR_RETURN    = 8'h0D;
  localparam logic [7:0]        CHAR_SPACE     = 8'h20;
  localparam logic [CELL_W-1:0] CELL_RESET     = 16'h0F20;

  localparam logic [COLOUR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOUR_W-1:0] BG_RESET = 4'h0;

  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CH_NONE,
    CH_BACKSPACE,
    CH_TAB,
    CH_RETURN,
    CH_NEWLINE,
    CH_PRINT
  } char_class_t;

  typedef struct packed {
    op_t                  op;
    char_class_t          cls;
    logic [7:0]           char_code;
    logic [LOC_OUT_W-1:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [LOC_OUT_W-1:0] cursor_location;
    logic [CELL_W-1:0]    cell_data;
    logic                 scrolled;
  } res_t;

endpackage

>>> rtl/cwr_fifo.sv
module cwr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/cwr_front.sv
module cwr_front
  import cwr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 hold,
  output logic                 full,
  input  logic [1:0]           opcode,
  input  logic [7:0]           char_code,
  input  logic [LOC_OUT_W-1:0] cell_index,
  input  logic                 cmd_pop,
  output logic                 cmd_empty,
  output cmd_t                 cmd
);

  cmd_t cmd_in;
  logic q_full;

  always_comb begin
    cmd_in.op         = op_t'(opcode);
    cmd_in.char_code  = char_code;
    cmd_in.cell_index = cell_index;
    priority if (char_code == CHAR_BACKSPACE) begin
      cmd_in.cls = CH_BACKSPACE;
    end else if (char_code == CHAR_TAB) begin
      cmd_in.cls = CH_TAB;
    end else if (char_code == CHAR_RETURN) begin
      cmd_in.cls = CH_RETURN;
    end else if (char_code == CHAR_NEWLINE) begin
      cmd_in.cls = CH_NEWLINE;
    end else if (!char_code[7] && char_code >= CHAR_SPACE) begin
      cmd_in.cls = CH_PRINT;
    end else begin
      // other control codes and the high half are dropped
      cmd_in.cls = CH_NONE;
    end
  end

  assign full = q_full || hold;

  cwr_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (push && !full),
    .wr_data(cmd_in),
    .full   (q_full),
    .rd     (cmd_pop),
    .rd_data(cmd),
    .empty  (cmd_empty)
  );

endmodule

>>> rtl/cwr_back.sv
module cwr_back
  import cwr_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] attr,
  input  logic       cmd_empty,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic       res_full,
  output logic       res_push,
  output res_t       res,
  output logic       init_busy
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int MOVE  = (ROWS - 1) * COLUMNS;
  localparam int LOC_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int CT_W  = $clog2(COLUMNS + TAB_WIDTH + 1);
  localparam int RT_W  = $clog2(ROWS + 1);
  localparam int PH_W  = $clog2(TAB_WIDTH);
  localparam int IDX_W = LOC_OUT_W + 2;

  typedef enum logic [1:0] {S_FILL, S_IDLE, S_READ, S_SCROLL} state_t;

  function automatic logic [LOC_W-1:0] loc_of(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c);
    loc_of = LOC_W'(LOC_W'(r) * LOC_W'(COLUMNS) + LOC_W'(c));
  endfunction

  logic [CELL_W-1:0] mem [CELLS];

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              init_pass, init_pass_next;
  logic [CELL_W-1:0] fill_cell, fill_cell_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [PH_W-1:0]   phase, phase_next;
  logic              p_valid, p_valid_next;
  logic [LOC_W-1:0]  p_addr, p_addr_next;
  logic [LOC_W-1:0]  res_loc, res_loc_next;
  logic              res_scrolled, res_scrolled_next;
  logic              rd_oob, rd_oob_next;

  logic              wr_en;
  logic [LOC_W-1:0]  wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [LOC_W-1:0]  rd_addr;
  logic [CELL_W-1:0] rd_data;

  logic [CT_W-1:0]   col_t;
  logic [RT_W-1:0]   row_t;
  logic [PH_W-1:0]   ph_t;
  logic [COL_W-1:0]  col_fin;
  logic [ROW_W-1:0]  row_fin;
  logic              need_scroll;

  assign init_busy = init_pass;

  // cursor rules for a put beat
  always_comb begin
    col_t = CT_W'(col);
    row_t = RT_W'(row);
    ph_t  = phase;
    unique case (cmd.cls)
      CH_BACKSPACE: begin
        if (col != '0) begin
          col_t = CT_W'(col) - 1'b1;
          ph_t  = (phase == '0) ? PH_W'(TAB_WIDTH - 1) : phase - 1'b1;
        end
      end
      CH_TAB: begin
        col_t = CT_W'(col) + CT_W'(TAB_WIDTH) - CT_W'(phase);
        ph_t  = '0;
      end
      CH_RETURN: begin
        col_t = '0;
        ph_t  = '0;
      end
      CH_NEWLINE: begin
        col_t = '0;
        row_t = RT_W'(row) + 1'b1;
        ph_t  = '0;
      end
      CH_PRINT: begin
        col_t = CT_W'(col) + 1'b1;
        ph_t  = (phase == PH_W'(TAB_WIDTH - 1)) ? '0 : phase + 1'b1;
      end
      default: begin
      end
    endcase
    if (col_t >= CT_W'(COLUMNS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
      ph_t  = '0;
    end
    need_scroll = (row_t >= RT_W'(ROWS));
    col_fin     = COL_W'(col_t);
    row_fin     = need_scroll ? ROW_W'(ROWS - 1) : ROW_W'(row_t);
  end

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    init_pass_next    = init_pass;
    fill_cell_next    = fill_cell;
    col_next          = col;
    row_next          = row;
    phase_next        = phase;
    p_valid_next      = p_valid;
    p_addr_next       = p_addr;
    res_loc_next      = res_loc;
    res_scrolled_next = res_scrolled;
    rd_oob_next       = rd_oob;
    wr_en             = 1'b0;
    wr_addr           = loc_of(row, col);
    wr_data           = {attr, cmd.char_code};
    rd_en             = 1'b0;
    rd_addr           = LOC_W'(cmd.cell_index);
    cmd_pop           = 1'b0;
    res_push          = 1'b0;
    res.cursor_location = LOC_OUT_W'(loc_of(row, col));
    res.cell_data       = '0;
    res.scrolled        = 1'b0;

    unique case (state)
      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = cnt[LOC_W-1:0];
        wr_data = fill_cell;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(CELLS - 1)) begin
          state_next     = S_IDLE;
          init_pass_next = 1'b0;
          if (!init_pass) begin
            res_push            = 1'b1;
            res.cursor_location = LOC_OUT_W'(res_loc);
            res.scrolled        = res_scrolled;
          end
        end
      end
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_PUT: begin
              wr_en      = (cmd.cls == CH_PRINT);
              col_next   = col_fin;
              row_next   = row_fin;
              phase_next = ph_t;
              if (need_scroll) begin
                state_next        = S_SCROLL;
                cnt_next          = '0;
                p_valid_next      = 1'b0;
                res_loc_next      = loc_of(row_fin, col_fin);
                res_scrolled_next = 1'b1;
              end else begin
                res_push            = 1'b1;
                res.cursor_location = LOC_OUT_W'(loc_of(row_fin, col_fin));
              end
            end
            OP_CLEAR: begin
              state_next        = S_FILL;
              cnt_next          = '0;
              fill_cell_next    = {attr, CHAR_SPACE};
              col_next          = '0;
              row_next          = '0;
              phase_next        = '0;
              res_loc_next      = '0;
              res_scrolled_next = 1'b0;
            end
            OP_READ: begin
              rd_en       = 1'b1;
              rd_oob_next = !(IDX_W'(cmd.cell_index) < IDX_W'(CELLS));
              state_next  = S_READ;
            end
            OP_NOP: begin
              res_push = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_push      = 1'b1;
        res.cell_data = rd_oob ? '0 : rd_data;
        state_next    = S_IDLE;
      end
      S_SCROLL: begin
        // read one row below, write the word read on the previous cycle
        wr_en   = p_valid;
        wr_addr = p_addr;
        wr_data = rd_data;
        if (cnt < CNT_W'(MOVE)) begin
          rd_en        = 1'b1;
          rd_addr      = LOC_W'(cnt + CNT_W'(COLUMNS));
          p_valid_next = 1'b1;
          p_addr_next  = cnt[LOC_W-1:0];
          cnt_next     = cnt + 1'b1;
        end else begin
          p_valid_next   = 1'b0;
          fill_cell_next = {attr, CHAR_SPACE};
          state_next     = S_FILL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      cnt          <= '0;
      init_pass    <= 1'b1;
      fill_cell    <= CELL_RESET;
      col          <= '0;
      row          <= '0;
      phase        <= '0;
      p_valid      <= 1'b0;
      p_addr       <= '0;
      res_loc      <= '0;
      res_scrolled <= 1'b0;
      rd_oob       <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      init_pass    <= init_pass_next;
      fill_cell    <= fill_cell_next;
      col          <= col_next;
      row          <= row_next;
      phase        <= phase_next;
      p_valid      <= p_valid_next;
      p_addr       <= p_addr_next;
      res_loc      <= res_loc_next;
      res_scrolled <= res_scrolled_next;
      rd_oob       <= rd_oob_next;
    end
  end

endmodule

>>> rtl/text_console_char_writer_top.sv
// Text console character engine: a ROWS x COLUMNS screen of 16-bit cells
// (attribute high byte, character low byte) plus a cursor.
// Input queue: push/full with opcode, char_code, cell_index. An item is taken
// on a clock edge with push high and full low. Result queue: empty/pop; the
// oldest result sits on cursor_location, cell_data, scrolled while empty is
// low and leaves on an edge with pop high. Exactly one result per item.
// Config channel cfg_valid/cfg_ready (always ready): index 0 foreground,
// index 1 background, other indexes are dropped.
// Item handling, bound by the single-write/single-read screen memory in the
// engine: a put that does not scroll or an unused opcode is answered from
// the idle state, a cell read passes through a read state, a clear sweeps
// every cell, and a put that scrolls copies the rows up (pipelined one cell
// per cycle) and then blanks the bottom row.
// After reset the engine sweeps every cell to white-on-black spaces; full
// stays high meanwhile. A two-beat command queue and a two-beat result queue
// decouple the sides; when the receiver stalls the engine holds once the
// result queue is full and full rises after the command queue fills.
module text_console_char_writer_top
  import cwr_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           opcode,
  input  logic [7:0]           char_code,
  input  logic [LOC_OUT_W-1:0] cell_index,
  output logic                 empty,
  input  logic                 pop,
  output logic [LOC_OUT_W-1:0] cursor_location,
  output logic [CELL_W-1:0]    cell_data,
  output logic                 scrolled,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOUR_W-1:0]  cfg_data
);

  logic [COLOUR_W-1:0] fg;
  logic [COLOUR_W-1:0] bg;
  logic                init_busy;
  logic                cmd_empty;
  logic                cmd_pop;
  cmd_t                cmd;
  logic                res_full;
  logic                res_push;
  res_t                res_in;
  res_t                res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FOREGROUND) begin
        fg <= cfg_data;
      end else if (cfg_index == REG_BACKGROUND) begin
        bg <= cfg_data;
      end
    end
  end

  cwr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .hold      (init_busy),
    .full      (full),
    .opcode    (opcode),
    .char_code (char_code),
    .cell_index(cell_index),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  cwr_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .attr     ({bg, fg}),
    .cmd_empty(cmd_empty),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in),
    .init_busy(init_busy)
  );

  cwr_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .rd     (pop),
    .rd_data(res_out),
    .empty  (empty)
  );

  assign cursor_location = res_out.cursor_location;
  assign cell_data       = res_out.cell_data;
  assign scrolled        = res_out.scrolled;

endmodule

>>> tb/tb.sv
module tb;
  import cwr_pkg::*;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int TABW  = 4;
  localparam int CELLS = ROWS * COLS;
  localparam logic [7:0] CHAR_LAST_PRINT = 8'h7F;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [1:0]           opcode = OP_PUT;
  logic [7:0]           char_code = 8'h00;
  logic [LOC_OUT_W-1:0] cell_index = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [LOC_OUT_W-1:0] cursor_location;
  logic [CELL_W-1:0]    cell_data;
  logic                 scrolled;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FOREGROUND;
  logic [COLOUR_W-1:0]  cfg_data = '0;

  text_console_char_writer_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------- console model ----------------
  logic [CELL_W-1:0]   screen_model [0:CELLS-1];
  int unsigned         cur_col, cur_row;
  logic [COLOUR_W-1:0] fg_model, bg_model;

  res_t awaited_results [$];
  int   errors, items_sent, n_reads, n_clears, n_scrolls, n_settings;

  function automatic logic [CELL_W-1:0] attr_cell(logic [7:0] ch);
    return {bg_model, fg_model, ch};
  endfunction

  function automatic res_t console_apply(op_t op, logic [7:0] ch, logic [LOC_OUT_W-1:0] idx);
    res_t r;
    int unsigned i;
    r = '0;
    case (op)
      OP_PUT: begin
        if (ch == CHAR_BACKSPACE) begin
          if (cur_col != 0) cur_col--;
        end else if (ch == CHAR_TAB) begin
          cur_col = cur_col + TABW - (cur_col % TABW);
        end else if (ch == CHAR_RETURN) begin
          cur_col = 0;
        end else if (ch == CHAR_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (ch >= CHAR_SPACE && ch <= CHAR_LAST_PRINT) begin
          screen_model[cur_row * COLS + cur_col] = attr_cell(ch);
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (i = 0; i < (ROWS - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
          for (i = (ROWS - 1) * COLS; i < CELLS; i++) screen_model[i] = attr_cell(CHAR_SPACE);
          cur_row = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_model[i] = attr_cell(CHAR_SPACE);
        cur_col = 0;
        cur_row = 0;
      end
      OP_READ: begin
        if (idx < CELLS) r.cell_data = screen_model[idx];
      end
      default: ;
    endcase
    r.cursor_location = LOC_OUT_W'(cur_row * COLS + cur_col);
    return r;
  endfunction

  // ---------------- result side ----------------
  res_t want;

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: cursor_location %0d", cursor_location);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (cursor_location !== want.cursor_location) begin
          $error("cursor_location: expected %0d, got %0d", want.cursor_location, cursor_location);
          errors++;
        end
        if (cell_data !== want.cell_data) begin
          $error("cell_data: expected %04h, got %04h", want.cell_data, cell_data);
          errors++;
        end
        if (scrolled !== want.scrolled) begin
          $error("scrolled: expected %0b, got %0b", want.scrolled, scrolled);
          errors++;
        end
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int n;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        // stretch with the receiver always ready
        pop <= 1'b1;
        repeat (200) @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          pop <= 1'b0;
          repeat (n) @(posedge clk);
        end
        pop <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // ---------------- sender side ----------------
  typedef struct {
    op_t                  op;
    logic [7:0]           ch;
    logic [LOC_OUT_W-1:0] idx;
    bit                   typed;
    res_t                 res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_row(op_t op, logic [7:0] ch, logic [LOC_OUT_W-1:0] idx,
                                  bit typed = 1'b0, logic [LOC_OUT_W-1:0] loc = '0,
                                  logic [CELL_W-1:0] cell_val = '0);
    dir_row_t d;
    d.op    = op;
    d.ch    = ch;
    d.idx   = idx;
    d.typed = typed;
    d.res.cursor_location = loc;
    d.res.cell_data       = cell_val;
    d.res.scrolled        = 1'b0;
    dir_rows.push_back(d);
  endfunction

  task automatic send_item(op_t op, logic [7:0] ch, logic [LOC_OUT_W-1:0] idx,
                           bit typed, res_t typed_res);
    res_t r;
    push       <= 1'b1;
    opcode     <= op;
    char_code  <= ch;
    cell_index <= idx;
    do @(posedge clk); while (full);
    r = console_apply(op, ch, idx);
    if (r.scrolled) n_scrolls++;
    if (op == OP_READ) n_reads++;
    if (op == OP_CLEAR) n_clears++;
    awaited_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  task automatic sender_gap(int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // cfg_valid stays up across back-to-back beats
  task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [COLOUR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FOREGROUND) fg_model = val;
    else if (idx == REG_BACKGROUND) bg_model = val;
  endtask

  task automatic set_colours(logic [COLOUR_W-1:0] fg, logic [COLOUR_W-1:0] bg, bit junk);
    wait_idle();
    cfg_beat(REG_FOREGROUND, fg);
    cfg_beat(REG_BACKGROUND, bg);
    if (junk) begin
      // writes to unmapped indexes must not disturb the colours
      cfg_beat(REG_UNUSED_2, ~fg);
      cfg_beat(REG_UNUSED_3, ~bg);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic random_items(int count, bit no_gaps);
    op_t        op;
    logic [7:0] ch;
    logic [LOC_OUT_W-1:0] idx;
    int r;
    res_t none;
    none = '0;
    repeat (count) begin
      r   = $urandom_range(0, 999);
      ch  = 8'($urandom_range(0, 255));
      idx = LOC_OUT_W'($urandom_range(0, 2047));
      if (r < 5) op = OP_CLEAR;
      else if (r < 15) op = OP_NOP;
      else if (r < 160) begin
        op = OP_READ;
        if ($urandom_range(0, 9) != 0) idx = LOC_OUT_W'($urandom_range(0, CELLS - 1));
      end else begin
        op = OP_PUT;
        r  = $urandom_range(0, 99);
        if (r < 55) ch = 8'($urandom_range(CHAR_SPACE, CHAR_LAST_PRINT));
        else if (r < 70) ch = CHAR_NEWLINE;
        else if (r < 76) ch = CHAR_TAB;
        else if (r < 82) ch = CHAR_BACKSPACE;
        else if (r < 86) ch = CHAR_RETURN;
      end
      send_item(op, ch, idx, 1'b0, none);
      sender_gap(no_gaps ? 0 : gap_len());
    end
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) screen_model[i] = CELL_RESET;
    cur_col  = 0;
    cur_row  = 0;
    fg_model = FG_RESET;
    bg_model = BG_RESET;

    add_row(OP_READ,  8'h00,          11'd0,    1'b1, 11'd0,  CELL_RESET);
    add_row(OP_READ,  8'hFF,          11'd1999, 1'b1, 11'd0,  CELL_RESET);
    add_row(OP_READ,  8'h00,          11'd2000, 1'b1, 11'd0,  16'h0000);
    add_row(OP_READ,  8'h00,          11'd2047, 1'b1, 11'd0,  16'h0000);
    add_row(OP_NOP,   8'hFF,          11'd2047, 1'b1, 11'd0,  16'h0000);
    add_row(OP_PUT,   8'h41,          11'd0,    1'b1, 11'd1,  16'h0000);
    add_row(OP_READ,  8'h00,          11'd0,    1'b1, 11'd1,  16'h0F41);
    add_row(OP_PUT,   CHAR_BACKSPACE, 11'd0,    1'b1, 11'd0,  16'h0000);
    add_row(OP_PUT,   CHAR_BACKSPACE, 11'd0,    1'b1, 11'd0,  16'h0000);
    add_row(OP_PUT,   CHAR_TAB,       11'd0,    1'b1, 11'd4,  16'h0000);
    add_row(OP_PUT,   CHAR_TAB,       11'd0,    1'b1, 11'd8,  16'h0000);
    add_row(OP_PUT,   CHAR_RETURN,    11'd0,    1'b1, 11'd0,  16'h0000);
    add_row(OP_PUT,   CHAR_NEWLINE,   11'd0,    1'b1, 11'd80, 16'h0000);
    add_row(OP_PUT,   8'h01,          11'd0,    1'b1, 11'd80, 16'h0000);
    add_row(OP_PUT,   8'h80,          11'd0,    1'b1, 11'd80, 16'h0000);
    add_row(OP_PUT,   8'hFF,          11'd2047, 1'b1, 11'd80, 16'h0000);
    add_row(OP_PUT,   CHAR_LAST_PRINT, 11'd0,   1'b1, 11'd81, 16'h0000);
    add_row(OP_PUT,   CHAR_SPACE,     11'd0,    1'b1, 11'd82, 16'h0000);
    add_row(OP_READ,  8'h00,          11'd80,   1'b1, 11'd82, 16'h0F7F);
    add_row(OP_PUT,   CHAR_NEWLINE,   11'd0);
    add_row(OP_CLEAR, 8'h00,          11'd0,    1'b1, 11'd0,  16'h0000);
    add_row(OP_READ,  8'h00,          11'd80,   1'b1, 11'd0,  CELL_RESET);
    add_row(OP_PUT,   8'h7E,          11'd5);
    add_row(OP_READ,  8'h00,          11'd0);

    while (rst) @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].idx,
                dir_rows[i].typed, dir_rows[i].res);
      sender_gap(gap_len());
    end

    set_colours(4'h0, 4'h0, 1'b1);
    random_items(175, 1'b0);
    set_colours(4'hF, 4'hF, 1'b0);
    random_items(175, 1'b1);
    set_colours(4'h0, 4'hF, 1'b1);
    random_items(175, 1'b0);
    set_colours(4'hF, 4'h0, 1'b0);
    random_items(175, 1'b0);
    repeat (2) begin
      set_colours(COLOUR_W'($urandom_range(0, 15)), COLOUR_W'($urandom_range(0, 15)), 1'b1);
      random_items(175, 1'b0);
    end

    wait_idle();
    repeat (20) @(posedge clk);

    $display("covered %0d items: %0d cell reads, %0d clears, %0d scrolls", items_sent,
             n_reads, n_clears, n_scrolls);
    $display("across %0d colour settings, %0d mismatches", n_settings, errors);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #250_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
